FILE: hdl/rti_pkg.sv
package rti_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int DIR_BITS_DEF   = 16;
    localparam int LIMB_BITS      = 24;
    localparam int NUM_UOPS       = 24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        A_D0, A_D1, A_D2,
        A_E1_0, A_E1_1, A_E1_2,
        A_E2_0, A_E2_1, A_E2_2,
        A_S0, A_S1, A_S2
    } opa_t;

    typedef enum logic [3:0] {
        B_E1_0, B_E1_1, B_E1_2,
        B_E2_0, B_E2_1, B_E2_2,
        B_P0, B_P1, B_P2,
        B_Q0, B_Q1, B_Q2
    } opb_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_P0, DST_P1, DST_P2,
        DST_Q0, DST_Q1, DST_Q2,
        DST_DET, DST_UN, DST_VN, DST_TN
    } dst_t;

    typedef struct packed {
        opa_t opa;
        opb_t opb;
        logic neg;
        logic clr;
        dst_t dst;
    } uop_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic neg;
        logic last;
        dst_t dst;
    } mac_ctl_t;

    typedef struct packed {
        logic valid;
        dst_t dst;
    } mac_wb_t;

    // p = d x e2, det = e1.p, un = s.p, q = s x e1, vn = d.q, tn = e2.q
    function automatic uop_t get_uop(input logic [4:0] idx);
        uop_t u;
        u = '{A_D0, B_E1_0, 1'b0, 1'b0, DST_NONE};
        unique case (idx)
            5'd0:  u = '{A_D1,   B_E2_2, 1'b0, 1'b1, DST_NONE};
            5'd1:  u = '{A_D2,   B_E2_1, 1'b1, 1'b0, DST_P0};
            5'd2:  u = '{A_D2,   B_E2_0, 1'b0, 1'b1, DST_NONE};
            5'd3:  u = '{A_D0,   B_E2_2, 1'b1, 1'b0, DST_P1};
            5'd4:  u = '{A_D0,   B_E2_1, 1'b0, 1'b1, DST_NONE};
            5'd5:  u = '{A_D1,   B_E2_0, 1'b1, 1'b0, DST_P2};
            5'd6:  u = '{A_E1_0, B_P0,   1'b0, 1'b1, DST_NONE};
            5'd7:  u = '{A_E1_1, B_P1,   1'b0, 1'b0, DST_NONE};
            5'd8:  u = '{A_E1_2, B_P2,   1'b0, 1'b0, DST_DET};
            5'd9:  u = '{A_S0,   B_P0,   1'b0, 1'b1, DST_NONE};
            5'd10: u = '{A_S1,   B_P1,   1'b0, 1'b0, DST_NONE};
            5'd11: u = '{A_S2,   B_P2,   1'b0, 1'b0, DST_UN};
            5'd12: u = '{A_S1,   B_E1_2, 1'b0, 1'b1, DST_NONE};
            5'd13: u = '{A_S2,   B_E1_1, 1'b1, 1'b0, DST_Q0};
            5'd14: u = '{A_S2,   B_E1_0, 1'b0, 1'b1, DST_NONE};
            5'd15: u = '{A_S0,   B_E1_2, 1'b1, 1'b0, DST_Q1};
            5'd16: u = '{A_S0,   B_E1_1, 1'b0, 1'b1, DST_NONE};
            5'd17: u = '{A_S1,   B_E1_0, 1'b1, 1'b0, DST_Q2};
            5'd18: u = '{A_D0,   B_Q0,   1'b0, 1'b1, DST_NONE};
            5'd19: u = '{A_D1,   B_Q1,   1'b0, 1'b0, DST_NONE};
            5'd20: u = '{A_D2,   B_Q2,   1'b0, 1'b0, DST_VN};
            5'd21: u = '{A_E2_0, B_Q0,   1'b0, 1'b1, DST_NONE};
            5'd22: u = '{A_E2_1, B_Q1,   1'b0, 1'b0, DST_NONE};
            5'd23: u = '{A_E2_2, B_Q2,   1'b0, 1'b0, DST_TN};
            default: u = '{A_D0, B_E1_0, 1'b0, 1'b0, DST_NONE};
        endcase
        return u;
    endfunction

endpackage

FILE: hdl/rti_if.sv
interface rti_req_if #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
    parameter int DIR_BITS   = rti_pkg::DIR_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [1:0]                   vertex_sel;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [DIR_BITS-1:0]   dir_x;
    logic signed [DIR_BITS-1:0]   dir_y;
    logic signed [DIR_BITS-1:0]   dir_z;

    modport source (output valid, req_type, vertex_sel, point_x, point_y, point_z,
                    dir_x, dir_y, dir_z, input ready);
    modport sink   (input valid, req_type, vertex_sel, point_x, point_y, point_z,
                    dir_x, dir_y, dir_z, output ready);
endinterface

interface rti_res_if #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [COORD_BITS-1:0] hit_distance;

    modport source (output valid, hit, hit_distance, input ready);
    modport sink   (input valid, hit, hit_distance, output ready);
endinterface

FILE: hdl/rti_mac.sv
module rti_mac #(
    parameter int MA = 25,
    parameter int L  = 24,
    parameter int LW = 2,
    parameter int AW = 80
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic signed [MA-1:0] a,
    input  logic signed [L:0]    b_limb,
    input  logic [LW-1:0]        limb,
    input  rti_pkg::mac_ctl_t    ctl,
    output logic signed [AW-1:0] acc,
    output rti_pkg::mac_wb_t     wb
);

    logic signed [MA+L:0]  prod_reg;
    rti_pkg::mac_ctl_t     ctl_reg;
    logic [LW-1:0]         limb_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [AW-1:0]  acc_next;
    logic signed [AW-1:0]  term;
    logic signed [AW-1:0]  term_sh;
    rti_pkg::mac_wb_t      wb_reg;
    rti_pkg::mac_wb_t      wb_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
            wb_reg  <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
            wb_reg  <= wb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b_limb;
        limb_reg <= limb;
        if (ctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        term    = AW'(prod_reg);
        term_sh = term <<< (32'(limb_reg) * L);
        acc_next = (ctl_reg.first ? '0 : acc_reg) + (ctl_reg.neg ? -term_sh : term_sh);
        wb_next.valid = ctl_reg.valid && ctl_reg.last && (ctl_reg.dst != rti_pkg::DST_NONE);
        wb_next.dst   = ctl_reg.dst;
    end

    assign acc = acc_reg;
    assign wb  = wb_reg;

endmodule

FILE: hdl/rti_div.sv
module rti_div #(
    parameter int NB = 24,
    parameter int AW = 80,
    parameter int DW = 118
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] num,
    input  logic [AW-1:0] den,
    output logic          done,
    output logic [NB-1:0] quo
);

    localparam int CW = $clog2(NB + 1);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dv_reg;
    logic [NB-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [DW-1:0] lim;
    logic          ge;

    assign lim = DW'(den) << NB;
    assign ge  = rem_reg >= dv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (num >= lim)
                begin
                    cnt_reg  <= '0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= CW'(NB);
                end
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dv_reg  <= DW'(den) << (NB - 1);
            quo_reg <= (num >= lim) ? '1 : '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? rem_reg - dv_reg : rem_reg;
            dv_reg  <= dv_reg >> 1;
            quo_reg <= {quo_reg[NB-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: hdl/ray_triangle_intersect_unit.sv
// Ray/triangle intersection (Moller-Trumbore) in exact fixed point. A load request
// (req_type 0) writes one vertex of the stored triangle and returns nothing. A test
// request (req_type 1) returns one result: hit and the distance along the ray in
// fixed point with DIR_BITS-2 fraction bits (Q.14 at default widths), saturated, zero
// on a miss. All cross and dot products run through one shared multiplier that takes
// the wide operand a limb at a time: 24 multiply steps over ceil(operand/24) limbs each
// (3 at default widths), a multiplier drain and a check, then the bit-serial divider
// (which gives all ones without iterating when the distance saturates and is skipped
// on a miss), and then the result is registered. The request side is not ready while
// a test is in progress, nor while a finished result waits on a full output register,
// and is ready again in the cycle after the result is registered.
module ray_triangle_intersect_unit #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
    parameter int DIR_BITS   = rti_pkg::DIR_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    rti_req_if.sink   req,
    rti_res_if.source res
);

    localparam int C    = COORD_BITS;
    localparam int EW   = C + 1;
    localparam int PW   = DIR_BITS + EW + 1;
    localparam int QW   = 2 * EW + 1;
    localparam int MA   = (EW > DIR_BITS) ? EW : DIR_BITS;
    localparam int BW   = (QW > PW) ? QW : PW;
    localparam int L    = rti_pkg::LIMB_BITS;
    localparam int NL   = (BW + L - 1) / L;
    localparam int LW   = (NL > 1) ? $clog2(NL) : 1;
    localparam int BXW  = NL * L;
    localparam int AW0  = EW + QW + 2;
    localparam int AW1  = DIR_BITS + QW + 2;
    localparam int AW2  = EW + PW + 2;
    localparam int AW01 = (AW0 > AW1) ? AW0 : AW1;
    localparam int AW   = ((AW01 > AW2) ? AW01 : AW2) + 1;
    localparam int DF   = DIR_BITS - 2;
    localparam int DW   = AW + C + DF;

    rti_pkg::state_t state_reg, state_next;

    logic signed [C-1:0]        vx_reg [3];
    logic signed [C-1:0]        vy_reg [3];
    logic signed [C-1:0]        vz_reg [3];
    logic signed [DIR_BITS-1:0] d_reg  [3];
    logic signed [EW-1:0]       e1_reg [3];
    logic signed [EW-1:0]       e2_reg [3];
    logic signed [EW-1:0]       s_reg  [3];
    logic signed [PW-1:0]       p_reg  [3];
    logic signed [QW-1:0]       q_reg  [3];
    logic signed [AW-1:0]       det_reg, un_reg, vn_reg, tn_reg;

    logic [4:0]           uop_idx_reg;
    logic [LW-1:0]        limb_reg;
    rti_pkg::uop_t        uop;
    logic                 last_limb;
    logic                 last_uop;
    rti_pkg::mac_ctl_t    ctl;
    logic signed [MA-1:0] a_val;
    logic signed [BW-1:0] b_val;
    logic [BXW-1:0]       bx;
    logic signed [L:0]    b_limb;
    logic signed [AW-1:0] acc;
    rti_pkg::mac_wb_t     wb;

    logic                 req_fire;
    logic                 load_fire;
    logic                 test_fire;
    logic                 flip;
    logic signed [AW+1:0] det_f, un_f, vn_f, tn_f;
    logic                 pass;
    logic                 div_start;
    logic [DW-1:0]        div_num;
    logic [AW-1:0]        div_den;
    logic                 div_done;
    logic [C-1:0]         div_quo;

    logic                 res_valid_reg;
    logic                 res_hit_reg;
    logic [C-1:0]         res_dist_reg;
    logic                 pend_hit_reg;
    logic [C-1:0]         pend_dist_reg;
    logic                 res_load;

    assign req_fire  = req.valid && req.ready;
    assign load_fire = req_fire && !req.req_type;
    assign test_fire = req_fire && req.req_type;

    // ---------------- state machine
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rti_pkg::ST_IDLE:  if (test_fire) state_next = rti_pkg::ST_ISSUE;
            rti_pkg::ST_ISSUE: if (last_limb && last_uop) state_next = rti_pkg::ST_DRAIN;
            rti_pkg::ST_DRAIN:
                if (wb.valid && wb.dst == rti_pkg::DST_TN) state_next = rti_pkg::ST_CHECK;
            rti_pkg::ST_CHECK: state_next = pass ? rti_pkg::ST_DIV : rti_pkg::ST_DONE;
            rti_pkg::ST_DIV:   if (div_done) state_next = rti_pkg::ST_DONE;
            rti_pkg::ST_DONE:  if (!res_valid_reg || res.ready) state_next = rti_pkg::ST_IDLE;
            default:           state_next = rti_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        ctl       = '0;
        div_start = 1'b0;
        res_load  = 1'b0;
        unique case (state_reg)
            rti_pkg::ST_IDLE:  req.ready = 1'b1;
            rti_pkg::ST_ISSUE:
            begin
                ctl.valid = 1'b1;
                ctl.first = uop.clr && (limb_reg == '0);
                ctl.neg   = uop.neg;
                ctl.last  = last_limb;
                ctl.dst   = uop.dst;
            end
            rti_pkg::ST_DRAIN: ;
            rti_pkg::ST_CHECK: div_start = pass;
            rti_pkg::ST_DIV:   ;
            rti_pkg::ST_DONE:  res_load = !res_valid_reg || res.ready;
            default:           ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rti_pkg::ST_IDLE;
            uop_idx_reg   <= '0;
            limb_reg      <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
                vz_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_fire && req.vertex_sel != 2'd3)
            begin
                vx_reg[req.vertex_sel] <= req.point_x;
                vy_reg[req.vertex_sel] <= req.point_y;
                vz_reg[req.vertex_sel] <= req.point_z;
            end
            if (test_fire)
            begin
                uop_idx_reg <= '0;
                limb_reg    <= '0;
            end
            else if (state_reg == rti_pkg::ST_ISSUE)
            begin
                if (last_limb)
                begin
                    limb_reg    <= '0;
                    uop_idx_reg <= uop_idx_reg + 1'b1;
                end
                else
                begin
                    limb_reg <= limb_reg + 1'b1;
                end
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- operand capture and write-back
    always_ff @(posedge clk)
    begin
        if (test_fire)
        begin
            d_reg[0]  <= req.dir_x;
            d_reg[1]  <= req.dir_y;
            d_reg[2]  <= req.dir_z;
            e1_reg[0] <= EW'(vx_reg[1]) - EW'(vx_reg[0]);
            e1_reg[1] <= EW'(vy_reg[1]) - EW'(vy_reg[0]);
            e1_reg[2] <= EW'(vz_reg[1]) - EW'(vz_reg[0]);
            e2_reg[0] <= EW'(vx_reg[2]) - EW'(vx_reg[0]);
            e2_reg[1] <= EW'(vy_reg[2]) - EW'(vy_reg[0]);
            e2_reg[2] <= EW'(vz_reg[2]) - EW'(vz_reg[0]);
            s_reg[0]  <= EW'(req.point_x) - EW'(vx_reg[0]);
            s_reg[1]  <= EW'(req.point_y) - EW'(vy_reg[0]);
            s_reg[2]  <= EW'(req.point_z) - EW'(vz_reg[0]);
        end
        if (wb.valid)
        begin
            unique case (wb.dst)
                rti_pkg::DST_P0:  p_reg[0] <= PW'(acc);
                rti_pkg::DST_P1:  p_reg[1] <= PW'(acc);
                rti_pkg::DST_P2:  p_reg[2] <= PW'(acc);
                rti_pkg::DST_Q0:  q_reg[0] <= QW'(acc);
                rti_pkg::DST_Q1:  q_reg[1] <= QW'(acc);
                rti_pkg::DST_Q2:  q_reg[2] <= QW'(acc);
                rti_pkg::DST_DET: det_reg  <= acc;
                rti_pkg::DST_UN:  un_reg   <= acc;
                rti_pkg::DST_VN:  vn_reg   <= acc;
                rti_pkg::DST_TN:  tn_reg   <= acc;
                default:          ;
            endcase
        end
        if (state_reg == rti_pkg::ST_CHECK && !pass)
        begin
            pend_hit_reg  <= 1'b0;
            pend_dist_reg <= '0;
        end
        else if (div_done)
        begin
            pend_hit_reg  <= 1'b1;
            pend_dist_reg <= div_quo;
        end
        if (res_load)
        begin
            res_hit_reg  <= pend_hit_reg;
            res_dist_reg <= pend_dist_reg;
        end
    end

    // ---------------- operand selection for the shared multiplier
    assign uop       = rti_pkg::get_uop(uop_idx_reg);
    assign last_limb = limb_reg == LW'(NL - 1);
    assign last_uop  = uop_idx_reg == 5'(rti_pkg::NUM_UOPS - 1);

    always_comb
    begin
        unique case (uop.opa)
            rti_pkg::A_D0:   a_val = MA'(d_reg[0]);
            rti_pkg::A_D1:   a_val = MA'(d_reg[1]);
            rti_pkg::A_D2:   a_val = MA'(d_reg[2]);
            rti_pkg::A_E1_0: a_val = MA'(e1_reg[0]);
            rti_pkg::A_E1_1: a_val = MA'(e1_reg[1]);
            rti_pkg::A_E1_2: a_val = MA'(e1_reg[2]);
            rti_pkg::A_E2_0: a_val = MA'(e2_reg[0]);
            rti_pkg::A_E2_1: a_val = MA'(e2_reg[1]);
            rti_pkg::A_E2_2: a_val = MA'(e2_reg[2]);
            rti_pkg::A_S0:   a_val = MA'(s_reg[0]);
            rti_pkg::A_S1:   a_val = MA'(s_reg[1]);
            rti_pkg::A_S2:   a_val = MA'(s_reg[2]);
            default:         a_val = '0;
        endcase
        unique case (uop.opb)
            rti_pkg::B_E1_0: b_val = BW'(e1_reg[0]);
            rti_pkg::B_E1_1: b_val = BW'(e1_reg[1]);
            rti_pkg::B_E1_2: b_val = BW'(e1_reg[2]);
            rti_pkg::B_E2_0: b_val = BW'(e2_reg[0]);
            rti_pkg::B_E2_1: b_val = BW'(e2_reg[1]);
            rti_pkg::B_E2_2: b_val = BW'(e2_reg[2]);
            rti_pkg::B_P0:   b_val = BW'(p_reg[0]);
            rti_pkg::B_P1:   b_val = BW'(p_reg[1]);
            rti_pkg::B_P2:   b_val = BW'(p_reg[2]);
            rti_pkg::B_Q0:   b_val = BW'(q_reg[0]);
            rti_pkg::B_Q1:   b_val = BW'(q_reg[1]);
            rti_pkg::B_Q2:   b_val = BW'(q_reg[2]);
            default:         b_val = '0;
        endcase
        bx = BXW'(b_val);
        // lower limbs are unsigned, the top one carries the sign
        if (last_limb)
            b_limb = $signed({bx[BXW-1], bx[limb_reg*L +: L]});
        else
            b_limb = $signed({1'b0, bx[limb_reg*L +: L]});
    end

    rti_mac #(.MA(MA), .L(L), .LW(LW), .AW(AW)) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .a      (a_val),
        .b_limb (b_limb),
        .limb   (limb_reg),
        .ctl    (ctl),
        .acc    (acc),
        .wb     (wb)
    );

    // ---------------- hit tests, normalised to det > 0
    always_comb
    begin
        flip  = det_reg[AW-1];
        det_f = flip ? -(AW+2)'(det_reg) : (AW+2)'(det_reg);
        un_f  = flip ? -(AW+2)'(un_reg)  : (AW+2)'(un_reg);
        vn_f  = flip ? -(AW+2)'(vn_reg)  : (AW+2)'(vn_reg);
        tn_f  = flip ? -(AW+2)'(tn_reg)  : (AW+2)'(tn_reg);
        pass  = (det_reg != '0) && !un_f[AW+1] && !vn_f[AW+1]
             && (un_f <= det_f) && (un_f + vn_f <= det_f)
             && !tn_f[AW+1] && (tn_f != '0);
        div_num = DW'(tn_f[AW-1:0]) << DF;
        div_den = det_f[AW-1:0];
    end

    rti_div #(.NB(C), .AW(AW), .DW(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign res.valid        = res_valid_reg;
    assign res.hit          = res_hit_reg;
    assign res.hit_distance = res_dist_reg;

endmodule

FILE: hdl/rti_checker.sv
module rti_checker #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  req_type,
    input logic                  res_valid,
    input logic                  res_ready,
    input logic                  hit,
    input logic [COORD_BITS-1:0] hit_distance
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before it was taken");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !hit |-> hit_distance == '0)
        else $error("miss with nonzero distance");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !req_type |=> !$rose(res_valid))
        else $error("load request produced a result");

    a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type |=> !req_ready)
        else $error("ready while a test is in progress");

endmodule

bind ray_triangle_intersect_unit rti_checker #(.COORD_BITS(COORD_BITS)) u_rti_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_type     (req.req_type),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .hit          (res.hit),
    .hit_distance (res.hit_distance)
);
